FILE: rtl/core/hlva_pkg.sv
// Shared types, constants and trigonometry table for the Hough line vote accumulator.
package hlva_pkg;

    localparam int unsigned IMAGE_WIDTH_DEF  = 512;
    localparam int unsigned IMAGE_HEIGHT_DEF = 512;
    localparam int unsigned NUM_ANGLES_DEF   = 180;
    localparam int unsigned RHO_BINS_DEF     = 1450;

    localparam int unsigned COUNT_W       = 16;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [15:0] THRESHOLD_RST = 16'd200;
    localparam int unsigned Q_FRAC        = 14;
    localparam int unsigned RHO_W         = 11;

    // round(16384 * sin(d degrees)) for d = 0..90
    localparam logic [14:0] QUARTER_SINE [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
        15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
        15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
        15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
        15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
        15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
        15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
        15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
        15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
        15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
        15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
        15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_RHO,
        ST_ADDR,
        ST_READ,
        ST_WRITE,
        ST_EMIT
    } hlva_state_t;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } hlva_rho_ctl_t;

    // Q2.14 sine of an angle in 0..359 degrees
    function automatic logic signed [15:0] sin_q14(input logic [8:0] deg);
        logic [8:0]  idx;
        logic        neg;
        logic [14:0] mag;
        priority if (deg <= 9'd90)
        begin
            idx = deg;
            neg = 1'b0;
        end
        else if (deg <= 9'd180)
        begin
            idx = 9'd180 - deg;
            neg = 1'b0;
        end
        else if (deg <= 9'd270)
        begin
            idx = deg - 9'd180;
            neg = 1'b1;
        end
        else
        begin
            idx = 9'd360 - deg;
            neg = 1'b1;
        end
        mag = (idx <= 9'd90) ? QUARTER_SINE[idx[6:0]] : 15'd0;
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

FILE: rtl/core/hlva_ram.sv
// Generic simple dual-port RAM with registered read.
module hlva_ram #(
    parameter int unsigned WIDTH  = 16,
    parameter int unsigned DEPTH  = 1024,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/hlva_rho.sv
// Rho computation: table lookup and products, then sum, truncation and bin range check.
module hlva_rho #(
    parameter int unsigned RHO_BINS = hlva_pkg::RHO_BINS_DEF,
    localparam int unsigned BIN_W   = $clog2(RHO_BINS)
) (
    input  logic                    clk,
    input  hlva_pkg::hlva_rho_ctl_t ctl,
    input  logic [8:0]              pixel_x,
    input  logic [8:0]              pixel_y,
    input  logic [7:0]              angle,
    output logic signed [10:0]      rho,
    output logic [BIN_W-1:0]        bin,
    output logic                    in_range
);

    localparam logic signed [14:0] HALF_BINS = 15'(RHO_BINS / 2);
    localparam logic signed [14:0] NUM_BINS  = 15'(RHO_BINS);

    logic signed [15:0] cos_val;
    logic signed [15:0] sin_val;
    logic signed [25:0] prod_x_next, prod_x_reg;
    logic signed [25:0] prod_y_next, prod_y_reg;
    logic signed [26:0] sum;
    logic signed [26:0] sum_adj;
    logic signed [12:0] rho_full;
    logic signed [14:0] bin_s;
    logic signed [10:0]      rho_next, rho_reg;
    logic [BIN_W-1:0]        bin_next, bin_reg;
    logic                    in_range_next, in_range_reg;

    always_comb
    begin
        sin_val     = hlva_pkg::sin_q14({1'b0, angle});
        cos_val     = hlva_pkg::sin_q14({1'b0, angle} + 9'd90);
        prod_x_next = $signed({1'b0, pixel_x}) * cos_val;
        prod_y_next = $signed({1'b0, pixel_y}) * sin_val;
    end

    // Truncate toward zero: bias negative sums before the arithmetic shift
    always_comb
    begin
        sum           = 27'(prod_x_reg) + 27'(prod_y_reg);
        sum_adj       = sum + (sum[26] ? 27'sd16383 : 27'sd0);
        rho_full      = sum_adj[26:hlva_pkg::Q_FRAC];
        bin_s         = 15'(rho_full) + HALF_BINS;
        rho_next      = rho_full[10:0];
        bin_next      = bin_s[BIN_W-1:0];
        in_range_next = !bin_s[14] && (bin_s < NUM_BINS);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
        if (ctl.sum_en)
        begin
            rho_reg      <= rho_next;
            bin_reg      <= bin_next;
            in_range_reg <= in_range_next;
        end
    end

    assign rho      = rho_reg;
    assign bin      = bin_reg;
    assign in_range = in_range_reg;

endmodule

FILE: rtl/core/hough_line_vote_accumulator_top.sv
// Hough line vote accumulator: request control, vote store and result register.
// A vote request runs through MUL, RHO, ADDR, READ and WRITE before the next is taken; the
// result is loaded in WRITE, or in EMIT while the output stalls. One request is in flight:
// lookup/multiply, sum, address, store read and write-back run in turn on the single store
// port pair. Zero-pixel or out-of-range requests are dropped in IDLE, off-bin rhos in ADDR.
// After reset and after each clear request the store is swept to zero, one counter per
// cycle (RHO_BINS * NUM_ANGLES counters, 261000 at defaults); no request is taken meanwhile.
module hough_line_vote_accumulator_top #(
    parameter int unsigned IMAGE_WIDTH  = hlva_pkg::IMAGE_WIDTH_DEF,
    parameter int unsigned IMAGE_HEIGHT = hlva_pkg::IMAGE_HEIGHT_DEF,
    parameter int unsigned NUM_ANGLES   = hlva_pkg::NUM_ANGLES_DEF,
    parameter int unsigned RHO_BINS     = hlva_pkg::RHO_BINS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        vote_threshold,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  logic [8:0]         pixel_x,
    input  logic [8:0]         pixel_y,
    input  logic [7:0]         pixel_value,
    input  logic [7:0]         angle_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         line_theta,
    output logic signed [10:0] line_rho
);

    localparam int unsigned DEPTH  = RHO_BINS * NUM_ANGLES;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned BIN_W  = $clog2(RHO_BINS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    hlva_pkg::hlva_state_t   state_reg, state_next;
    hlva_pkg::hlva_rho_ctl_t rho_ctl;

    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [15:0]       threshold_reg, threshold_next;
    logic [8:0]        x_reg, x_next;
    logic [8:0]        y_reg, y_next;
    logic [7:0]        ang_reg, ang_next;
    logic [ADDR_W-1:0] slot_reg, slot_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        theta_reg, theta_next;
    logic signed [10:0] rho_out_reg, rho_out_next;

    logic signed [10:0] rho;
    logic [BIN_W-1:0]   bin;
    logic               in_range;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [15:0]       ram_wr_data;
    logic              ram_rd_en;
    logic [15:0]       ram_rd_data;

    logic        vote_ok;
    logic [15:0] cnt_inc;
    logic        not_sat;
    logic        hit;
    logic        out_free;
    logic        out_load;

    hlva_rho #(
        .RHO_BINS (RHO_BINS)
    ) u_rho (
        .clk      (clk),
        .ctl      (rho_ctl),
        .pixel_x  (x_reg),
        .pixel_y  (y_reg),
        .angle    (ang_reg),
        .rho      (rho),
        .bin      (bin),
        .in_range (in_range)
    );

    hlva_ram #(
        .WIDTH (hlva_pkg::COUNT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (slot_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        vote_ok  = (pixel_value != 8'd0)
                && (9'(angle_index) < 9'(NUM_ANGLES))
                && (13'(pixel_x) < 13'(IMAGE_WIDTH))
                && (13'(pixel_y) < 13'(IMAGE_HEIGHT));
        cnt_inc  = ram_rd_data + 16'd1;
        not_sat  = ram_rd_data != hlva_pkg::COUNT_MAX;
        hit      = not_sat && (cnt_inc == threshold_reg);
        out_free = !out_valid_reg || out_ready;
    end

    // Next state
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            hlva_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = hlva_pkg::ST_IDLE;
                end
            end
            hlva_pkg::ST_IDLE:
            begin
                priority if (in_valid && req_type)
                begin
                    state_next    = hlva_pkg::ST_CLEAR;
                    clr_addr_next = '0;
                end
                else if (in_valid && vote_ok)
                begin
                    state_next = hlva_pkg::ST_MUL;
                end
                else
                begin
                    state_next = hlva_pkg::ST_IDLE;
                end
            end
            hlva_pkg::ST_MUL:   state_next = hlva_pkg::ST_RHO;
            hlva_pkg::ST_RHO:   state_next = hlva_pkg::ST_ADDR;
            hlva_pkg::ST_ADDR:
            begin
                state_next = in_range ? hlva_pkg::ST_READ : hlva_pkg::ST_IDLE;
            end
            hlva_pkg::ST_READ:  state_next = hlva_pkg::ST_WRITE;
            hlva_pkg::ST_WRITE:
            begin
                state_next = (hit && !out_free) ? hlva_pkg::ST_EMIT : hlva_pkg::ST_IDLE;
            end
            hlva_pkg::ST_EMIT:
            begin
                state_next = out_free ? hlva_pkg::ST_IDLE : hlva_pkg::ST_EMIT;
            end
            default:            state_next = hlva_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready       = 1'b0;
        rho_ctl.mul_en = 1'b0;
        rho_ctl.sum_en = 1'b0;
        ram_rd_en      = 1'b0;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = slot_reg;
        ram_wr_data    = cnt_inc;
        out_load       = 1'b0;
        unique case (state_reg)
            hlva_pkg::ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_addr_reg;
                ram_wr_data = '0;
            end
            hlva_pkg::ST_IDLE:  in_ready = 1'b1;
            hlva_pkg::ST_MUL:   rho_ctl.mul_en = 1'b1;
            hlva_pkg::ST_RHO:   rho_ctl.sum_en = 1'b1;
            hlva_pkg::ST_ADDR:  ;
            hlva_pkg::ST_READ:  ram_rd_en = 1'b1;
            hlva_pkg::ST_WRITE:
            begin
                // drop the write on a saturated counter
                ram_wr_en = not_sat;
                out_load  = hit && out_free;
            end
            hlva_pkg::ST_EMIT:  out_load = out_free;
            default:            ;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        x_next         = x_reg;
        y_next         = y_reg;
        ang_next       = ang_reg;
        slot_next      = slot_reg;
        theta_next     = theta_reg;
        rho_out_next   = rho_out_reg;
        threshold_next = cfg_valid ? vote_threshold : threshold_reg;
        if (in_valid && in_ready)
        begin
            x_next   = pixel_x;
            y_next   = pixel_y;
            ang_next = angle_index;
        end
        if (state_reg == hlva_pkg::ST_ADDR)
        begin
            slot_next = ADDR_W'(bin) * ADDR_W'(NUM_ANGLES) + ADDR_W'(ang_reg);
        end
        if (out_load)
        begin
            theta_next   = ang_reg;
            rho_out_next = rho;
        end
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hlva_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            threshold_reg <= hlva_pkg::THRESHOLD_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            threshold_reg <= threshold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        ang_reg     <= ang_next;
        slot_reg    <= slot_next;
        theta_reg   <= theta_next;
        rho_out_reg <= rho_out_next;
    end

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign line_theta = theta_reg;
    assign line_rho   = rho_out_reg;

    a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && req_type) |=> (state_reg == hlva_pkg::ST_CLEAR))
        else $error("clear request did not start the store sweep");

    a_no_write_past_saturation: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && state_reg == hlva_pkg::ST_WRITE) |-> (ram_rd_data != hlva_pkg::COUNT_MAX))
        else $error("saturated counter written back");

    a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == hlva_pkg::ST_WRITE
                                  || $past(state_reg) == hlva_pkg::ST_EMIT))
        else $error("result raised outside write-back");

    a_no_request_during_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hlva_pkg::ST_CLEAR) |-> (!in_ready && ram_wr_en && ram_wr_data == 16'd0))
        else $error("store sweep interrupted");

endmodule

FILE: tb/testbench.sv
// Testbench for the Hough line vote accumulator: directed table, random vote streams, line check.
`timescale 1ns / 1ps

module testbench;

    localparam int IMG_W      = 512;
    localparam int IMG_H      = 512;
    localparam int ANGLES     = 180;
    localparam int RHO_SPAN   = 1450;
    localparam int Q_ONE      = 16384;
    localparam int SETTLE     = 8;
    localparam int PHASES     = 8;
    localparam int PHASE_VOTES = 250;
    localparam int PLAN_LEN   = 26;
    localparam real PI        = 3.14159265358979323846;

    typedef enum logic
    {
        REQ_VOTE  = 1'b0,
        REQ_CLEAR = 1'b1
    } req_kind_t;

    typedef enum logic
    {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef enum logic [1:0]
    {
        CHK_MODEL,
        CHK_NONE,
        CHK_LINE
    } row_check_t;

    typedef struct packed
    {
        logic [7:0]         theta;
        logic signed [10:0] rho;
    } line_t;

    typedef struct packed
    {
        row_kind_t          kind;
        req_kind_t          req;
        logic [8:0]         x;
        logic [8:0]         y;
        logic [7:0]         pix;
        logic [7:0]         ang;
        logic [15:0]        thresh;
        row_check_t         chk;
        logic [7:0]         theta;
        logic signed [10:0] rho;
    } step_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        vote_threshold;
    logic               in_valid;
    logic               in_ready;
    logic               req_type;
    logic [8:0]         pixel_x;
    logic [8:0]         pixel_y;
    logic [7:0]         pixel_value;
    logic [7:0]         angle_index;
    logic               out_valid;
    logic               out_ready;
    logic [7:0]         line_theta;
    logic signed [10:0] line_rho;

    // predictor state: sparse copy of the vote store and the threshold
    logic [15:0] vote_tally [int];
    logic [15:0] vote_limit = hlva_pkg::THRESHOLD_RST;
    int          quarter_q14 [0:90];
    line_t       expected_lines [$];
    int          mismatches = 0;
    bit          steady_flow = 1'b0;
    step_t       plan [0:PLAN_LEN-1];

    hough_line_vote_accumulator_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .vote_threshold (vote_threshold),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .pixel_value    (pixel_value),
        .angle_index    (angle_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .line_theta     (line_theta),
        .line_rho       (line_rho)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int sine_q14(input int deg);
        int d;
        d = deg % 360;
        if (d <= 90)
            return quarter_q14[d];
        else if (d <= 180)
            return quarter_q14[180 - d];
        else if (d <= 270)
            return -quarter_q14[d - 180];
        return -quarter_q14[360 - d];
    endfunction

    // bump the tallied bin; report a line when it lands exactly on the threshold
    function automatic bit predict_vote(input logic [8:0] x, input logic [8:0] y,
                                        input logic [7:0] pix, input logic [7:0] ang,
                                        output line_t line);
        int          sum;
        int          rho;
        int          bin;
        int          slot;
        int unsigned count;
        line = '0;
        if (pix == 8'd0 || ang >= ANGLES || x >= IMG_W || y >= IMG_H)
            return 1'b0;
        sum = int'(x) * sine_q14(int'(ang) + 90) + int'(y) * sine_q14(int'(ang));
        rho = sum / Q_ONE;
        bin = rho + RHO_SPAN / 2;
        if (bin < 0 || bin >= RHO_SPAN)
            return 1'b0;
        slot  = bin * ANGLES + int'(ang);
        count = vote_tally.exists(slot) ? vote_tally[slot] : 0;
        if (count >= hlva_pkg::COUNT_MAX)
            return 1'b0;
        count = count + 1;
        vote_tally[slot] = count[15:0];
        if (count != vote_limit)
            return 1'b0;
        line.theta = ang;
        line.rho   = rho[10:0];
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_threshold();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 16'd1;
        else if (r < 85)
            return 16'($urandom_range(2, 6));
        else if (r < 93)
            return 16'($urandom_range(7, 24));
        return 16'($urandom_range(0, 65535));
    endfunction

    // hold the request until taken, then run the predictor on it
    task automatic offer_request(input req_kind_t req, input logic [8:0] x,
                                 input logic [8:0] y, input logic [7:0] pix,
                                 input logic [7:0] ang, input int gap,
                                 output bit hit, output line_t line);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        pixel_x     <= x;
        pixel_y     <= y;
        pixel_value <= pix;
        angle_index <= ang;
        do
            @(posedge clk);
        while (!in_ready);
        line = '0;
        if (req == REQ_CLEAR)
        begin
            vote_tally.delete();
            hit = 1'b0;
        end
        else
            hit = predict_vote(x, y, pix, ang, line);
    endtask

    task automatic push_request(input req_kind_t req, input logic [8:0] x,
                                input logic [8:0] y, input logic [7:0] pix,
                                input logic [7:0] ang);
        bit    hit;
        line_t line;
        offer_request(req, x, y, pix, ang, pick_gap(), hit, line);
        if (hit)
            expected_lines = {expected_lines, line};
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_lines.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        wait_drained();
        cfg_valid      <= 1'b1;
        vote_threshold <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        vote_limit = value;
    endtask

    // result sink: runs of ready, short and long stalls, and a long hold-off now and then
    initial
    begin
        int run;
        int gap;
        int granted;
        int next_hold;
        granted   = 0;
        next_hold = 40;
        out_ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 12);
            out_ready <= 1'b1;
            repeat (run)
            begin
                @(posedge clk);
                if (out_valid && out_ready)
                    granted++;
            end
            if (granted >= next_hold)
            begin
                gap       = 300;
                next_hold = granted + 500;
            end
            else
            begin
                gap = $urandom_range(0, 99);
                if (gap < 70)
                    gap = $urandom_range(1, 2);
                else if (gap < 95)
                    gap = $urandom_range(3, 8);
                else
                    gap = $urandom_range(20, 60);
            end
            out_ready <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_lines
        line_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_lines.size() == 0)
            begin
                $error("unexpected line: theta %0d rho %0d", line_theta, line_rho);
                mismatches++;
            end
            else
            begin
                want = expected_lines.pop_front();
                if (line_theta !== want.theta)
                begin
                    $error("line_theta: expected %0d, actual %0d", want.theta, line_theta);
                    mismatches++;
                end
                if (line_rho !== want.rho)
                begin
                    $error("line_rho: expected %0d, actual %0d", want.rho, line_rho);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int          i;
        int          phase;
        int          votes;
        int          r;
        int          p;
        int          a;
        int          window;
        bit          paused;
        bit          hit;
        line_t       line;
        logic [8:0]  pool_x [0:3];
        logic [8:0]  pool_y [0:3];

        rst_n          <= 1'b0;
        cfg_valid      <= 1'b0;
        vote_threshold <= '0;
        in_valid       <= 1'b0;
        req_type       <= REQ_VOTE;
        pixel_x        <= '0;
        pixel_y        <= '0;
        pixel_value    <= '0;
        angle_index    <= '0;
        for (i = 0; i <= 90; i++)
            quarter_q14[i] = $rtoi(16384.0 * $sin(i * PI / 180.0) + 0.5);

        plan = '{
            '{ROW_ITEM, REQ_VOTE,    0,   0, 255,   0,     0, CHK_NONE,    0,   0},
            '{ROW_CFG,  REQ_VOTE,    0,   0,   0,   0,     1, CHK_NONE,    0,   0},
            '{ROW_ITEM, REQ_VOTE,    0,   0,   1,   0,     0, CHK_NONE,    0,   0},
            '{ROW_ITEM, REQ_VOTE,  511,   0, 255,   0,     0, CHK_LINE,    0, 511},
            '{ROW_ITEM, REQ_VOTE,    0, 511, 128,  90,     0, CHK_LINE,   90, 511},
            '{ROW_ITEM, REQ_VOTE,  511, 511, 255, 135,     0, CHK_LINE,  135,   0},
            '{ROW_ITEM, REQ_VOTE,  511, 511, 255,  45,     0, CHK_MODEL,   0,   0},
            '{ROW_ITEM, REQ_VOTE,  511,   0, 255, 179,     0, CHK_MODEL,   0,   0},
            '{ROW_ITEM, REQ_VOTE,  511,   0, 255, 180,     0, CHK_NONE,    0,   0},
            '{ROW_ITEM, REQ_VOTE,  511, 511, 255, 255,     0, CHK_NONE,    0,   0},
            '{ROW_ITEM, REQ_VOTE,  300, 200,   0,  60,     0, CHK_NONE,    0,   0},
            '{ROW_ITEM, REQ_VOTE,  511,   0,   1,   0,     0, CHK_NONE,    0,   0},
            '{ROW_ITEM, REQ_VOTE,  256, 128, 170, 100,     0, CHK_MODEL,   0,   0},
            '{ROW_ITEM, REQ_VOTE,    1,   1,  85,   1,     0, CHK_MODEL,   0,   0},
            '{ROW_CFG,  REQ_VOTE,    0,   0,   0,   0,     2, CHK_NONE,    0,   0},
            '{ROW_ITEM, REQ_VOTE,   10,  20,   7,  30,     0, CHK_NONE,    0,   0},
            '{ROW_ITEM, REQ_VOTE,   10,  20,   7,  30,     0, CHK_MODEL,   0,   0},
            '{ROW_ITEM, REQ_CLEAR, 511, 511, 255, 255,     0, CHK_NONE,    0,   0},
            '{ROW_ITEM, REQ_VOTE,   10,  20,   7,  30,     0, CHK_NONE,    0,   0},
            '{ROW_ITEM, REQ_VOTE,   10,  20,   7,  30,     0, CHK_MODEL,   0,   0},
            '{ROW_CFG,  REQ_VOTE,    0,   0,   0,   0,     0, CHK_NONE,    0,   0},
            '{ROW_ITEM, REQ_VOTE,    5,   5,   9,  10,     0, CHK_NONE,    0,   0},
            '{ROW_ITEM, REQ_VOTE,    5,   5,   9,  10,     0, CHK_NONE,    0,   0},
            '{ROW_CFG,  REQ_VOTE,    0,   0,   0,   0, 65535, CHK_NONE,    0,   0},
            '{ROW_ITEM, REQ_VOTE,    5,   5,   9,  10,     0, CHK_NONE,    0,   0},
            '{ROW_ITEM, REQ_VOTE,  400, 300,  64, 150,     0, CHK_NONE,    0,   0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < PLAN_LEN; i++)
        begin
            if (plan[i].kind == ROW_CFG)
                write_threshold(plan[i].thresh);
            else
            begin
                offer_request(plan[i].req, plan[i].x, plan[i].y, plan[i].pix, plan[i].ang,
                              pick_gap(), hit, line);
                if (plan[i].chk == CHK_LINE)
                begin
                    line.theta = plan[i].theta;
                    line.rho   = plan[i].rho;
                    expected_lines = {expected_lines, line};
                end
                else if (plan[i].chk == CHK_MODEL && hit)
                    expected_lines = {expected_lines, line};
            end
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            write_threshold(pick_threshold());
            steady_flow = (phase % 3 == 1);
            if (phase == 4)
                push_request(REQ_CLEAR, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            // a few pixels swept over a narrow angle window pile votes on the same bins
            for (p = 0; p < 4; p++)
            begin
                pool_x[p] = 9'($urandom_range(0, 511));
                pool_y[p] = 9'($urandom_range(0, 511));
            end
            window = $urandom_range(0, ANGLES - 8);
            votes  = 0;
            paused = 1'b0;
            while (votes < PHASE_VOTES)
            begin
                if (phase == 2 && !paused && votes >= PHASE_VOTES / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    p = $urandom_range(0, 3);
                    for (a = 0; a < 8; a++)
                        push_request(REQ_VOTE, pool_x[p], pool_y[p],
                                     8'($urandom_range(1, 255)), 8'(window + a));
                    votes += 8;
                end
                else if (r < 85)
                begin
                    push_request(REQ_VOTE, 9'($urandom_range(0, 511)),
                                 9'($urandom_range(0, 511)),
                                 8'($urandom_range(1, 255)), 8'($urandom_range(0, ANGLES - 1)));
                    votes++;
                end
                else if (r < 93)
                    push_request(REQ_VOTE, 9'($urandom_range(0, 511)),
                                 9'($urandom_range(0, 511)),
                                 8'd0, 8'($urandom_range(0, 255)));
                else
                    push_request(REQ_VOTE, 9'($urandom_range(0, 511)),
                                 9'($urandom_range(0, 511)),
                                 8'($urandom_range(1, 255)), 8'($urandom_range(ANGLES, 255)));
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/hlva_pkg.sv
rtl/core/hlva_ram.sv
rtl/core/hlva_rho.sv
rtl/core/hough_line_vote_accumulator_top.sv
tb/testbench.sv
